// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file mbr_checker.sv
// assumes clk and rst_n are visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define MBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never holds outside reset
`define MBR_NEVER(label, cond, msg) \
  `MBR_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/mbr_pkg.sv =====
// types and constants for the msb-first bit reader
// no dependencies
`timescale 1ns / 1ps

package mbr_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);

  localparam logic [5:0] MAX_READ      = 6'd32;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_APPEND    = 3'd1,
    OP_READ_BITS = 3'd2,
    OP_READ_BIT  = 3'd3,
    OP_READ_UE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UE_ZERO,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/msb_bit_reader_exp_golomb.sv =====
// msb-first bit reader with unsigned exp-golomb decode over a 4096-byte store
// start: no result; append: result strobe the cycle after the transfer
// read n bits: one ram fetch per stored byte entered
// read ue with i leading zeros: one fetch per byte entered, via the one read port
// bit engine: one bit per cycle, stalled while the single ram read port fetches
// rst_n is synchronous; byte and read counters clear, the store keeps its contents
`timescale 1ns / 1ps

module msb_bit_reader_exp_golomb
  import mbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_bit_count,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_ran_out,
  output logic        out_append_dropped
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0] read_index_r, read_index_nxt;
  logic [3:0]       bits_left_r, bits_left_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [5:0]       cnt_r, cnt_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      prefix_r, prefix_nxt;
  logic             miss_r, miss_nxt;
  logic [31:0]      out_value_r, out_value_nxt;
  logic             out_ran_out_r, out_ran_out_nxt;
  logic             out_dropped_r, out_dropped_nxt;

  logic             accept;
  logic             avail;
  logic             need_fetch;
  logic [3:0]       bl_dec;
  logic [2:0]       bit_pos;
  logic             bit_val;
  logic [CNT_W-1:0] adv_index;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  assign accept = start && !busy;

  // bit engine: the current byte sits in the ram read register once fetched
  assign avail      = read_index_r < byte_count_r;
  assign need_fetch = avail && !cur_valid_r;
  assign bl_dec     = bits_left_r - 4'd1;
  assign bit_pos    = bl_dec[2:0];
  assign bit_val    = avail && ram_rdata[bit_pos];
  assign adv_index  = (bit_pos == 3'd0) ? read_index_r + CNT_W'(1) : read_index_r;

  assign ram_we = accept && (in_opcode == OP_APPEND) && (byte_count_r < CNT_W'(BUF_BYTES));
  assign ram_re = need_fetch &&
                  ((state_r == ST_UE_ZERO) || ((state_r == ST_READ) && (cnt_r != 6'd0)));

  mbr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count_r[ADDR_W-1:0]),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (read_index_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      byte_count_r <= '0;
      read_index_r <= '0;
      bits_left_r  <= BITS_PER_BYTE;
      cur_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      read_index_r <= read_index_nxt;
      bits_left_r  <= bits_left_nxt;
      cur_valid_r  <= cur_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    acc_r         <= acc_nxt;
    prefix_r      <= prefix_nxt;
    miss_r        <= miss_nxt;
    out_value_r   <= out_value_nxt;
    out_ran_out_r <= out_ran_out_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    byte_count_nxt  = byte_count_r;
    read_index_nxt  = read_index_r;
    bits_left_nxt   = bits_left_r;
    cur_valid_nxt   = cur_valid_r;
    out_valid_nxt   = 1'b0;
    cnt_nxt         = cnt_r;
    acc_nxt         = acc_r;
    prefix_nxt      = prefix_r;
    miss_nxt        = miss_r;
    out_value_nxt   = out_value_r;
    out_ran_out_nxt = out_ran_out_r;
    out_dropped_nxt = out_dropped_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt    = '0;
          prefix_nxt = '0;
          miss_nxt   = 1'b0;
          case (op_t'(in_opcode))
            OP_START: begin
              byte_count_nxt = '0;
              read_index_nxt = '0;
              bits_left_nxt  = BITS_PER_BYTE;
              cur_valid_nxt  = 1'b0;
            end
            OP_APPEND: begin
              out_valid_nxt   = 1'b1;
              out_value_nxt   = '0;
              out_ran_out_nxt = 1'b0;
              out_dropped_nxt = !ram_we;
              if (ram_we) begin
                byte_count_nxt = byte_count_r + CNT_W'(1);
              end
            end
            OP_READ_BITS: begin
              cnt_nxt   = (in_bit_count > MAX_READ) ? MAX_READ : in_bit_count;
              state_nxt = ST_READ;
            end
            OP_READ_BIT: begin
              cnt_nxt   = 6'd1;
              state_nxt = ST_READ;
            end
            OP_READ_UE: begin
              cnt_nxt   = '0;
              state_nxt = ST_UE_ZERO;
            end
            default: ;
          endcase
        end
      end

      ST_UE_ZERO: begin
        if (!need_fetch) begin
          if (avail) begin
            read_index_nxt = adv_index;
            if (bit_pos == 3'd0) begin
              bits_left_nxt = BITS_PER_BYTE;
              cur_valid_nxt = 1'b0;
            end else begin
              bits_left_nxt = {1'b0, bit_pos};
            end
          end
          if (bit_val) begin
            state_nxt = ST_READ;
          end else if (!avail || (adv_index >= byte_count_r)) begin
            // zero bit left no data behind it
            miss_nxt  = 1'b1;
            state_nxt = ST_READ;
          end else if (cnt_r == MAX_READ) begin
            state_nxt = ST_READ;
          end else begin
            cnt_nxt    = cnt_r + 6'd1;
            prefix_nxt = {prefix_r[30:0], 1'b1};
          end
        end
      end

      ST_READ: begin
        if (cnt_r == 6'd0) begin
          state_nxt = ST_DONE;
        end else if (!need_fetch) begin
          acc_nxt = {acc_r[30:0], bit_val};
          cnt_nxt = cnt_r - 6'd1;
          if (avail) begin
            read_index_nxt = adv_index;
            if (bit_pos == 3'd0) begin
              bits_left_nxt = BITS_PER_BYTE;
              cur_valid_nxt = 1'b0;
            end else begin
              bits_left_nxt = {1'b0, bit_pos};
            end
          end else begin
            miss_nxt = 1'b1;
          end
        end
      end

      ST_DONE: begin
        // prefix is zero for plain reads; wraps mod 2^32 for 32 leading zeros
        out_valid_nxt   = 1'b1;
        out_value_nxt   = acc_r + prefix_r;
        out_ran_out_nxt = miss_r;
        out_dropped_nxt = 1'b0;
        state_nxt       = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // fetch marks the byte present for the next cycle
    if (ram_re) begin
      cur_valid_nxt = 1'b1;
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_ran_out        = out_ran_out_r;
  assign out_append_dropped = out_dropped_r;

endmodule

// ===== rtl/core/mbr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mbr_checker.sv =====
// port-level checks for msb_bit_reader_exp_golomb, bound to the top level
// depends on mbr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbr_checker
  import mbr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic [31:0] out_value,
  input logic        out_ran_out,
  input logic        out_append_dropped
);

  logic xfer;
  logic read_op;
  logic quiet_op;

  assign xfer     = start && !busy;
  assign read_op  = (in_opcode == OP_READ_BITS) || (in_opcode == OP_READ_BIT) ||
                    (in_opcode == OP_READ_UE);
  assign quiet_op = !read_op && (in_opcode != OP_APPEND);

  // a read transfer keeps the block occupied
  `MBR_ASSERT(a_read_goes_busy, (xfer && read_op) |=> busy, "read transfer did not raise busy")

  // start and unused opcodes give no result
  `MBR_ASSERT(a_quiet_no_result, (xfer && quiet_op) |=> !out_valid, "result after a quiet transfer")

  // append answers on the next cycle with a zero value and no ran_out
  `MBR_ASSERT(a_append_result, (xfer && (in_opcode == OP_APPEND)) |=> (out_valid && (out_value == 32'd0) && !out_ran_out), "bad append result")

  // a read finishing delivers its result as busy drops
  `MBR_ASSERT(a_read_ends_with_result, ($past(rst_n) && $fell(busy)) |-> (out_valid && !out_append_dropped), "busy fell without a read result")

  `MBR_NEVER(a_no_result_while_busy_starts, out_valid && busy && $past(busy) && $past(out_valid), "two results in a row during a read")

endmodule

bind msb_bit_reader_exp_golomb mbr_checker u_mbr_checker (.*);
